FILE: src/dna_pkg.sv
// Shared types, constants and helpers for the dual number ALU.
// No dependencies; imported by dna_div, dual_number_alu and tb_dual_number_alu.
package dna_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // quotient bits produced by the divider, and the depth of the delay line that runs beside it
    localparam int DIV_QBITS     = 32;
    localparam int DIV_LAT       = DIV_QBITS + 1;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } t_action;

    // one slot of the delay line that runs beside the divider
    typedef struct packed {
        logic        is_div;
        logic        div_zero;
        logic        rr_neg;
        logic        rd_neg;
        logic        ovf;
        logic [31:0] res_real;
        logic [31:0] res_dual;
    } t_lane;

    // sign/magnitude to saturated 32-bit two's complement; msb is the overflow flag
    function automatic logic [32:0] sat_q(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (neg) begin
            if (mag > {32'd0, Q_MIN}) r = {1'b1, Q_MIN};
            else                      r = {1'b0, ~mag[31:0] + 32'd1};
        end else begin
            if (mag > {32'd0, Q_MAX}) r = {1'b1, Q_MAX};
            else                      r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction

endpackage

FILE: src/dna_div.sv
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), one quotient bit per stage.
// o_big flags a quotient of 2^32 or more. Depends on dna_pkg.
module dna_div import dna_pkg::*; #(
    parameter int W         = 64,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    output logic          o_big,
    output logic [31:0]   o_quo
);
    localparam int SH = 32 - FRAC_BITS;

    logic [W-1:0]  r_rem [0:DIV_QBITS-1];
    logic [W-1:0]  r_den [0:DIV_QBITS-1];
    logic [31:0]   r_xl  [0:DIV_QBITS-1];
    logic [31:0]   r_q   [0:DIV_QBITS];
    logic          r_big [0:DIV_QBITS];
    logic [W-1:0]  n_hi;

    // dividend is num << FRAC_BITS; its part above bit 31 is num >> SH
    assign n_hi = i_num >> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_hi;
            r_den[0] <= i_den;
            r_xl[0]  <= i_num[31:0] << FRAC_BITS;
            r_q[0]   <= '0;
            r_big[0] <= (n_hi >= i_den);
        end
    end

    for (genvar k = 1; k <= DIV_QBITS; k++) begin : g_stage
        logic [W:0]   t;
        logic [W+1:0] d;
        logic         qb;
        assign t  = {r_rem[k-1], r_xl[k-1][31]};
        assign d  = {1'b0, t} - {2'b00, r_den[k-1]};
        assign qb = ~d[W+1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= {r_q[k-1][30:0], qb};
                r_big[k] <= r_big[k-1];
            end
        end

        if (k < DIV_QBITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= qb ? d[W-1:0] : t[W-1:0];
                    r_den[k] <= r_den[k-1];
                    r_xl[k]  <= {r_xl[k-1][30:0], 1'b0};
                end
            end
        end
    end

    assign o_big = r_big[DIV_QBITS];
    assign o_quo = r_q[DIV_QBITS];

endmodule

FILE: src/dual_number_alu.sv
// Dual number ALU: add, subtract, multiply, divide on signed fixed-point dual operands.
// Throughput one item per cycle while the output is not stalled.
// The 32-stage bit-per-cycle divider sets the depth; a stalled output freezes the whole
// pipeline, and a one-entry input skid keeps one more transfer in flight.
// Reset (synchronous, active low) clears every valid bit; payload registers are not reset.
// Depends on dna_pkg and dna_div.
module dual_number_alu import dna_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_dual,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_dual,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_res_real,
    output logic signed [31:0] o_res_dual,
    output logic               o_div_zero,
    output logic               o_overflow
);
    logic en;

    // ---------------- input skid ----------------
    logic        r_sk_valid;
    t_action     r_sk_act;
    logic [31:0] r_sk_ar, r_sk_ad, r_sk_br, r_sk_bd;
    t_action     s_act;
    logic [31:0] s_ar, s_ad, s_br, s_bd;
    logic        s_valid;

    assign en      = ~o_valid | ~i_stall;
    assign o_stall = r_sk_valid;
    assign s_valid = r_sk_valid | i_valid;
    assign s_act   = r_sk_valid ? r_sk_act : t_action'(i_action);
    assign s_ar    = r_sk_valid ? r_sk_ar : i_a_real;
    assign s_ad    = r_sk_valid ? r_sk_ad : i_a_dual;
    assign s_br    = r_sk_valid ? r_sk_br : i_b_real;
    assign s_bd    = r_sk_valid ? r_sk_bd : i_b_dual;

    // ---------------- stage 1: magnitudes ----------------
    logic        r1_valid;
    t_action     r1_act;
    logic [31:0] r1_ar, r1_ad, r1_br, r1_bd;
    logic [31:0] r1_mar, r1_mad, r1_mbr, r1_mbd;

    // ---------------- stage 2: products and sums ----------------
    logic        r2_valid;
    t_action     r2_act;
    logic [63:0] r2_pr, r2_pab, r2_pad, r2_pc2;
    logic [32:0] r2_sr, r2_sd;
    logic        r2_sar, r2_sad, r2_sbr, r2_sbd;
    logic [31:0] r2_mar, r2_mbr;
    logic        r2_bz;
    logic [32:0] n2_sr, n2_sd;

    assign n2_sr = (r1_act == ACT_SUB) ? ({r1_ar[31], r1_ar} - {r1_br[31], r1_br})
                                       : ({r1_ar[31], r1_ar} + {r1_br[31], r1_br});
    assign n2_sd = (r1_act == ACT_SUB) ? ({r1_ad[31], r1_ad} - {r1_bd[31], r1_bd})
                                       : ({r1_ad[31], r1_ad} + {r1_bd[31], r1_bd});

    // ---------------- stage 3: combine ----------------
    logic        r3_valid;
    t_action     r3_act;
    logic        r3_bz;
    logic        r3_rr_neg, r3_rd_neg;
    logic [63:0] r3_rr_mag, r3_rd_mag, r3_c2;
    logic [31:0] r3_mar, r3_mbr;
    logic        n3_rr_neg, n3_rd_neg;
    logic [63:0] n3_rr_mag, n3_rd_mag;
    logic        w_xneg, w_yneg, w_neg;
    logic [63:0] w_mag, w_sum, w_yx;
    logic [64:0] w_xy;
    logic [32:0] a_sr, a_sd;

    // signed sum of ar*bd (negated for divide) and ad*br
    assign w_xneg = r2_sar ^ r2_sbd ^ (r2_act == ACT_DIV);
    assign w_yneg = r2_sad ^ r2_sbr;
    assign w_sum  = r2_pab + r2_pad;
    assign w_xy   = {1'b0, r2_pab} - {1'b0, r2_pad};
    assign w_yx   = r2_pad - r2_pab;
    assign a_sr   = r2_sr[32] ? (~r2_sr + 33'd1) : r2_sr;
    assign a_sd   = r2_sd[32] ? (~r2_sd + 33'd1) : r2_sd;

    always_comb begin
        priority if (w_xneg == w_yneg) begin
            w_neg = w_xneg;
            w_mag = w_sum;
        end else if (!w_xy[64]) begin
            w_neg = w_xneg;
            w_mag = w_xy[63:0];
        end else begin
            w_neg = w_yneg;
            w_mag = w_yx;
        end
    end

    always_comb begin
        unique case (r2_act)
            ACT_ADD, ACT_SUB: begin
                n3_rr_neg = r2_sr[32];
                n3_rr_mag = {31'd0, a_sr};
                n3_rd_neg = r2_sd[32];
                n3_rd_mag = {31'd0, a_sd};
            end
            ACT_MUL: begin
                n3_rr_neg = r2_sar ^ r2_sbr;
                n3_rr_mag = r2_pr >> FRAC_BITS;
                n3_rd_neg = w_neg;
                n3_rd_mag = w_mag >> FRAC_BITS;
            end
            default: begin
                n3_rr_neg = r2_sar ^ r2_sbr;
                n3_rr_mag = '0;
                n3_rd_neg = w_neg;
                n3_rd_mag = w_mag;
            end
        endcase
    end

    // ---------------- divider and delay line ----------------
    logic        dv_big_r, dv_big_d;
    logic [31:0] dv_quo_r, dv_quo_d;
    logic        r_lv   [0:DIV_LAT-1];
    t_lane       r_lane [0:DIV_LAT-1];
    t_lane       n_lane0;
    logic [32:0] q3_r, q3_d;

    dna_div #(.W(32), .FRAC_BITS(FRAC_BITS)) u_div_real (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r3_mar),
        .i_den (r3_mbr),
        .o_big (dv_big_r),
        .o_quo (dv_quo_r)
    );

    dna_div #(.W(64), .FRAC_BITS(FRAC_BITS)) u_div_dual (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r3_rd_mag),
        .i_den (r3_c2),
        .o_big (dv_big_d),
        .o_quo (dv_quo_d)
    );

    assign q3_r = sat_q(r3_rr_neg, r3_rr_mag);
    assign q3_d = sat_q(r3_rd_neg, r3_rd_mag);

    always_comb begin
        n_lane0          = '0;
        n_lane0.is_div   = (r3_act == ACT_DIV);
        n_lane0.div_zero = r3_bz;
        n_lane0.rr_neg   = r3_rr_neg;
        n_lane0.rd_neg   = r3_rd_neg;
        n_lane0.ovf      = q3_r[32] | q3_d[32];
        n_lane0.res_real = q3_r[31:0];
        n_lane0.res_dual = q3_d[31:0];
    end

    // ---------------- output stage ----------------
    t_lane       l_last;
    logic [32:0] qo_r, qo_d;
    logic [31:0] n_o_real, n_o_dual;
    logic        n_o_dz, n_o_ovf;

    assign l_last = r_lane[DIV_LAT-1];
    assign qo_r   = sat_q(l_last.rr_neg, {31'd0, dv_big_r, dv_quo_r});
    assign qo_d   = sat_q(l_last.rd_neg, {31'd0, dv_big_d, dv_quo_d});

    always_comb begin
        priority if (!l_last.is_div) begin
            n_o_real = l_last.res_real;
            n_o_dual = l_last.res_dual;
            n_o_dz   = 1'b0;
            n_o_ovf  = l_last.ovf;
        end else if (l_last.div_zero) begin
            n_o_real = '0;
            n_o_dual = '0;
            n_o_dz   = 1'b1;
            n_o_ovf  = 1'b0;
        end else begin
            n_o_real = qo_r[31:0];
            n_o_dual = qo_d[31:0];
            n_o_dz   = 1'b0;
            n_o_ovf  = qo_r[32] | qo_d[32];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_valid <= 1'b0;
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            o_valid    <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) r_lv[i] <= 1'b0;
        end else begin
            r_sk_valid <= en ? 1'b0 : (r_sk_valid | i_valid);
            if (en) begin
                r1_valid <= s_valid;
                r2_valid <= r1_valid;
                r3_valid <= r2_valid;
                r_lv[0]  <= r3_valid;
                for (int i = 1; i < DIV_LAT; i++) r_lv[i] <= r_lv[i-1];
                o_valid  <= r_lv[DIV_LAT-1];
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (!en && !r_sk_valid) begin
            r_sk_act <= t_action'(i_action);
            r_sk_ar  <= i_a_real;
            r_sk_ad  <= i_a_dual;
            r_sk_br  <= i_b_real;
            r_sk_bd  <= i_b_dual;
        end
        if (en) begin
            r1_act <= s_act;
            r1_ar  <= s_ar;
            r1_ad  <= s_ad;
            r1_br  <= s_br;
            r1_bd  <= s_bd;
            r1_mar <= s_ar[31] ? (~s_ar + 32'd1) : s_ar;
            r1_mad <= s_ad[31] ? (~s_ad + 32'd1) : s_ad;
            r1_mbr <= s_br[31] ? (~s_br + 32'd1) : s_br;
            r1_mbd <= s_bd[31] ? (~s_bd + 32'd1) : s_bd;

            r2_act <= r1_act;
            r2_pr  <= r1_mar * r1_mbr;
            r2_pab <= r1_mar * r1_mbd;
            r2_pad <= r1_mad * r1_mbr;
            r2_pc2 <= r1_mbr * r1_mbr;
            r2_sr  <= n2_sr;
            r2_sd  <= n2_sd;
            r2_sar <= r1_ar[31];
            r2_sad <= r1_ad[31];
            r2_sbr <= r1_br[31];
            r2_sbd <= r1_bd[31];
            r2_mar <= r1_mar;
            r2_mbr <= r1_mbr;
            r2_bz  <= (r1_mbr == 32'd0);

            r3_act    <= r2_act;
            r3_bz     <= r2_bz;
            r3_rr_neg <= n3_rr_neg;
            r3_rr_mag <= n3_rr_mag;
            r3_rd_neg <= n3_rd_neg;
            r3_rd_mag <= n3_rd_mag;
            r3_c2     <= r2_pc2;
            r3_mar    <= r2_mar;
            r3_mbr    <= r2_mbr;

            r_lane[0] <= n_lane0;
            for (int i = 1; i < DIV_LAT; i++) r_lane[i] <= r_lane[i-1];

            o_res_real <= n_o_real;
            o_res_dual <= n_o_dual;
            o_div_zero <= n_o_dz;
            o_overflow <= n_o_ovf;
        end
    end

    // ---------------- assertions ----------------
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_real == 0 && o_res_dual == 0 && !o_overflow)
        else $error("divide-by-zero result not cleared");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_res_real == Q_MAX || o_res_real == Q_MIN ||
                                  o_res_dual == Q_MAX || o_res_dual == Q_MIN)
        else $error("overflow flagged without a saturated part");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid && en |=> !r_sk_valid)
        else $error("skid entry not drained when pipeline advanced");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en && i_rst_n |=> $stable(r3_valid) && $stable(r_lv[DIV_LAT-1]))
        else $error("pipeline moved while output stalled");

endmodule

FILE: tb/tb_dual_number_alu.sv
// Self-checking testbench for dual_number_alu: directed table then random traffic.
// Depends on dna_pkg (t_action) and the dual_number_alu RTL.
module tb_dual_number_alu import dna_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1930;
    localparam int FB       = 16;
    localparam int DRAIN    = 60;

    typedef struct {
        logic [31:0] re;
        logic [31:0] du;
        logic        dz;
        logic        ov;
    } t_dres;

    typedef struct {
        t_action     act;
        logic [31:0] ar, ad, br, bd;
        logic        typed;
        t_dres       res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_action = ACT_ADD;
    logic signed [31:0] i_a_real = '0, i_a_dual = '0, i_b_real = '0, i_b_dual = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_res_real, o_res_dual;
    logic               o_div_zero, o_overflow;

    t_dres pending_q[$];
    int    errors = 0;
    int    n_sent = 0;
    int    n_recv = 0;
    int    n_ovf = 0;
    int    n_dz = 0;
    int    act_cnt[4] = '{0, 0, 0, 0};
    bit    long_hold_done = 0;

    dual_number_alu uut (.*);

    always #2 i_clk = ~i_clk;

    // clamp a sign/magnitude value into Q16.16
    function automatic logic [32:0] clamp_q(input logic neg, input logic [127:0] mag);
        if (neg) begin
            if (mag > 128'h8000_0000) return {1'b1, 32'h8000_0000};
            return {1'b0, 32'(-mag)};
        end
        if (mag > 128'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
        return {1'b0, mag[31:0]};
    endfunction

    function automatic t_dres dual_result(input t_action act, input logic [31:0] ar, ad, br, bd);
        logic signed [127:0] xar, xad, xbr, xbd, sr, sd;
        logic [127:0] mr, md;
        logic nr, nd;
        logic [32:0] cr, cd;
        t_dres r;
        xar = signed'(ar); xad = signed'(ad); xbr = signed'(br); xbd = signed'(bd);
        r.dz = 1'b0;
        case (act)
            ACT_ADD: begin sr = xar + xbr; sd = xad + xbd; end
            ACT_SUB: begin sr = xar - xbr; sd = xad - xbd; end
            ACT_MUL: begin sr = xar * xbr; sd = xar * xbd + xad * xbr; end
            default: begin sr = xar; sd = xad * xbr - xar * xbd; end
        endcase
        nr = sr < 0; mr = nr ? -sr : sr;
        nd = sd < 0; md = nd ? -sd : sd;
        if (act == ACT_MUL) begin
            mr = mr >> FB; md = md >> FB;
        end else if (act == ACT_DIV) begin
            if (xbr == 0) begin
                r.re = '0; r.du = '0; r.dz = 1'b1; r.ov = 1'b0;
                return r;
            end
            nr = (xar < 0) != (xbr < 0);
            mr = (mr << FB) / (xbr < 0 ? -xbr : xbr);
            md = (md << FB) / (xbr * xbr);
        end
        cr = clamp_q(nr, mr);
        cd = clamp_q(nd, md);
        r.re = cr[31:0]; r.du = cd[31:0]; r.ov = cr[32] | cd[32];
        return r;
    endfunction

    function automatic t_row mk(input t_action act, input logic [31:0] ar, ad, br, bd);
        t_row w;
        w.act = act; w.ar = ar; w.ad = ad; w.br = br; w.bd = bd; w.typed = 0;
        w.res = '{32'd0, 32'd0, 1'b0, 1'b0};
        return w;
    endfunction

    function automatic t_row mkx(input t_action act, input logic [31:0] ar, ad, br, bd,
                                 input logic [31:0] re, du, input logic dz, ov);
        t_row w;
        w = mk(act, ar, ad, br, bd);
        w.typed = 1; w.res = '{re, du, dz, ov};
        return w;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            2:       return 32'($signed($urandom_range(0, 511)) - 256);
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input t_row w);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
            : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= w.act;
        i_a_real <= w.ar; i_a_dual <= w.ad; i_b_real <= w.br; i_b_dual <= w.bd;
        // o_stall only moves at the rising edge, so its value at the falling edge holds
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        pending_q.push_back(w.typed ? w.res : dual_result(w.act, w.ar, w.ad, w.br, w.bd));
        act_cnt[w.act]++;
        n_sent++;
        @(posedge i_clk);
    endtask

    // result side: transfer happens at the next rising edge
    always @(negedge i_clk) begin
        t_dres e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_recv++;
            if (o_overflow) n_ovf++;
            if (o_div_zero) n_dz++;
            if (pending_q.size() == 0) begin
                $error("result transfer with nothing pending");
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_res_real !== e.re) begin
                    $error("res_real expected %h got %h", e.re, o_res_real); errors++;
                end
                if (o_res_dual !== e.du) begin
                    $error("res_dual expected %h got %h", e.du, o_res_dual); errors++;
                end
                if (o_div_zero !== e.dz) begin
                    $error("div_zero expected %b got %b", e.dz, o_div_zero); errors++;
                end
                if (o_overflow !== e.ov) begin
                    $error("overflow expected %b got %b", e.ov, o_overflow); errors++;
                end
            end
        end
    end

    // receiver stalls; one long hold-off once traffic is flowing
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && n_recv >= 300) begin
                long_hold_done = 1;
                i_stall <= 1'b1;
                hold = 150;
                while (hold > 0) begin
                    @(posedge i_clk);
                    hold--;
                end
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
                i_stall <= 1'b1;
                hold = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_row dir[$];
        t_row w;
        int drain;
        dir.push_back(mkx(ACT_ADD, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mkx(ACT_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1));
        dir.push_back(mkx(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 0, 1));
        dir.push_back(mkx(ACT_SUB, 32'h8000_0000, 0, 32'h0000_0001, 0,
                          32'h8000_0000, 0, 0, 1));
        dir.push_back(mkx(ACT_SUB, 32'h7FFF_FFFF, 5, 32'hFFFF_FFFF, 5,
                          32'h7FFF_FFFF, 0, 0, 1));
        dir.push_back(mkx(ACT_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 0,
                          32'h0001_0000, 32'h0002_0000, 0, 0));
        dir.push_back(mkx(ACT_MUL, 32'h8000_0000, 0, 32'h8000_0000, 0,
                          32'h7FFF_FFFF, 0, 0, 1));
        dir.push_back(mk(ACT_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        dir.push_back(mk(ACT_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF));
        dir.push_back(mkx(ACT_DIV, 32'h1234_5678, 32'h1, 0, 32'h7, 0, 0, 1, 0));
        dir.push_back(mkx(ACT_DIV, 32'h8000_0000, 32'h8000_0000, 0, 32'h8000_0000, 0, 0, 1, 0));
        dir.push_back(mkx(ACT_DIV, 32'h0001_0000, 0, 32'h0001_0000, 0,
                          32'h0001_0000, 0, 0, 0));
        dir.push_back(mk(ACT_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000));
        dir.push_back(mk(ACT_DIV, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        dir.push_back(mk(ACT_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000));
        dir.push_back(mk(ACT_DIV, 32'hFFFF_FFF9, 32'h5, 32'h8000_0000, 32'h8000_0000));
        dir.push_back(mk(ACT_SUB, 32'h0002_8000, 32'hFFFF_0000, 32'h0002_8000, 0));
        dir.push_back(mk(ACT_MUL, 32'hFFFE_0000, 32'h0000_4000, 32'h0003_0000, 32'hFFFF_C000));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[k]) send_item(dir[k]);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 1000) begin
                i_valid <= 1'b0;
                while (pending_q.size() != 0) @(posedge i_clk);
            end
            w = mk(t_action'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                   rand_operand(), rand_operand());
            send_item(w);
        end
        i_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < DRAIN) begin
            @(posedge i_clk);
            drain++;
        end

        $display("Sent %0d items (add %0d, sub %0d, mul %0d, div %0d), checked %0d results",
                 n_sent, act_cnt[ACT_ADD], act_cnt[ACT_SUB], act_cnt[ACT_MUL],
                 act_cnt[ACT_DIV], n_recv);
        $display("Saturated results: %0d, zero-divisor results: %0d", n_ovf, n_dz);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: dual_number_alu.f
src/dna_pkg.sv
src/dna_div.sv
src/dual_number_alu.sv
tb/tb_dual_number_alu.sv
